// File: hdl/jbl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jbl_pkg
// Types, codes and helper functions for the JSON byte lexer.
// ----------------------------------------------------------------------------
package jbl_pkg;

  // default width of position and length counters
  localparam int unsigned POS_WIDTH_DEF = 16;

  // width of position and length fields on the result stream
  localparam int unsigned FIELD_WIDTH = 16;

  // result queue depth and its counter widths
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  // bytes below this value are control bytes, illegal inside strings
  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_NUL     = 8'h00;

  // escape counter: idle, after backslash, first hex digit, end of \uXXXX
  localparam logic [2:0] ESC_NONE    = 3'd0;
  localparam logic [2:0] ESC_BSLASH  = 3'd1;
  localparam logic [2:0] ESC_HEX0    = 3'd2;
  localparam logic [2:0] ESC_HEX_END = 3'd6;

  // token kinds
  localparam logic [3:0] K_OBJ_BEGIN = 4'd0;
  localparam logic [3:0] K_OBJ_END   = 4'd1;
  localparam logic [3:0] K_ARR_BEGIN = 4'd2;
  localparam logic [3:0] K_ARR_END   = 4'd3;
  localparam logic [3:0] K_COMMA     = 4'd4;
  localparam logic [3:0] K_COLON     = 4'd5;
  localparam logic [3:0] K_STRING    = 4'd6;
  localparam logic [3:0] K_PRIM      = 4'd7;
  localparam logic [3:0] K_INVALID   = 4'd8;
  localparam logic [3:0] K_NONE      = 4'd9;

  // lexer mode
  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_STR  = 4'b0010,
    M_PRIM = 4'b0100,
    M_ERR  = 4'b1000
  } mode_t;

  // primitive recogniser state
  typedef enum logic [19:0] {
    L_INIT  = 20'h00001,
    L_N     = 20'h00002,
    L_NU    = 20'h00004,
    L_NUL   = 20'h00008,
    L_T     = 20'h00010,
    L_TR    = 20'h00020,
    L_TRU   = 20'h00040,
    L_F     = 20'h00080,
    L_FA    = 20'h00100,
    L_FAL   = 20'h00200,
    L_FALS  = 20'h00400,
    L_SIGN  = 20'h00800,
    L_ZERO  = 20'h01000,
    L_INT   = 20'h02000,
    L_DOT   = 20'h04000,
    L_FRAC  = 20'h08000,
    L_EXP   = 20'h10000,
    L_ESIGN = 20'h20000,
    L_EDIG  = 20'h40000,
    L_DONE  = 20'h80000
  } lit_t;

  // one result item
  typedef struct packed {
    logic [3:0]             kind;
    logic [FIELD_WIDTH-1:0] start;
    logic [FIELD_WIDTH-1:0] length;
    logic                   doc_end;
    logic                   run_end;
  } res_t;

  // outcome of one byte fed to the primitive recogniser
  typedef struct packed {
    logic bad;      // byte rejects the primitive
    logic emit_ok;  // primitive ended before this byte, byte is lexed again
    logic done;     // byte completes a literal
    lit_t nx;
  } prim_out_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic lit_t lit_next(input lit_t s, input logic [7:0] c);
    logic e;
    lit_t nx;
    e  = (c == "e") || (c == "E");
    nx = L_INIT;
    case (s)
      L_INIT: begin
        if (c == "n") nx = L_N;
        else if (c == "t") nx = L_T;
        else if (c == "f") nx = L_F;
        else if (c == "-") nx = L_SIGN;
        else if (c == "0") nx = L_ZERO;
        else if (is_digit(c)) nx = L_INT;
      end
      L_SIGN: begin
        if (c == "0") nx = L_ZERO;
        else if (is_digit(c)) nx = L_INT;
      end
      L_INT: begin
        if (is_digit(c)) nx = L_INT;
        else if (c == ".") nx = L_DOT;
        else if (e) nx = L_EXP;
      end
      L_ZERO: begin
        if (c == ".") nx = L_DOT;
        else if (e) nx = L_EXP;
      end
      L_DOT:  nx = is_digit(c) ? L_FRAC : L_INIT;
      L_FRAC: begin
        if (is_digit(c)) nx = L_FRAC;
        else if (e) nx = L_EXP;
      end
      L_EXP: begin
        if (is_digit(c)) nx = L_EDIG;
        else if ((c == "+") || (c == "-")) nx = L_ESIGN;
      end
      L_ESIGN, L_EDIG: nx = is_digit(c) ? L_EDIG : L_INIT;
      L_N:    nx = (c == "u") ? L_NU   : L_INIT;
      L_NU:   nx = (c == "l") ? L_NUL  : L_INIT;
      L_NUL:  nx = (c == "l") ? L_DONE : L_INIT;
      L_T:    nx = (c == "r") ? L_TR   : L_INIT;
      L_TR:   nx = (c == "u") ? L_TRU  : L_INIT;
      L_TRU:  nx = (c == "e") ? L_DONE : L_INIT;
      L_F:    nx = (c == "a") ? L_FA   : L_INIT;
      L_FA:   nx = (c == "l") ? L_FAL  : L_INIT;
      L_FAL:  nx = (c == "s") ? L_FALS : L_INIT;
      L_FALS: nx = (c == "e") ? L_DONE : L_INIT;
      default: nx = L_INIT;
    endcase
    return nx;
  endfunction

  // states in which the text so far is a complete number
  function automatic logic lit_complete(input lit_t s);
    return (s == L_INT) || (s == L_ZERO) || (s == L_FRAC) || (s == L_EDIG);
  endfunction

  function automatic prim_out_t prim_eval(input lit_t s, input logic [7:0] c);
    prim_out_t o;
    o.bad     = 1'b0;
    o.emit_ok = 1'b0;
    o.done    = 1'b0;
    o.nx      = lit_next(s, c);
    if (c == CH_NUL) begin
      o.bad = 1'b1;
    end else if (o.nx == L_INIT) begin
      if (lit_complete(s)) o.emit_ok = 1'b1;
      else o.bad = 1'b1;
    end else begin
      o.done = (o.nx == L_DONE);
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// File: hdl/json_byte_lexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// json_byte_lexer
// Streaming JSON tokenizer: one document byte in, zero to two tokens out.
// ----------------------------------------------------------------------------
// channel   dir  tdata                              tuser                  tlast
// s_axis    in   [7:0] text byte                    -                      doc_last
// m_axis    out  [15:0] token_start,                [3:0] token_kind,      doc_end
//                [31:16] token_length               [4] run_end
//
// One byte is taken every cycle unless s_axis_tready is low; a byte goes from
// the input register through the lexer logic into a four-entry result queue,
// from which its tokens are offered in order. A byte that yields two tokens
// has them offered one after the other; the queue absorbs this. s_axis_tready
// drops while a byte is held and fewer than two queue slots are free. Reset
// (rst, synchronous) empties both stages and returns the lexer to the start
// of a document.
// ----------------------------------------------------------------------------
module json_byte_lexer #(
  parameter int unsigned POS_WIDTH = jbl_pkg::POS_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input byte stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  wire logic        s_axis_tlast,   // doc_last
  // token stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [15:0] token_start, [31:16] token_length
  output logic [4:0]       m_axis_tuser,   // [3:0] token_kind, [4] run_end
  output logic             m_axis_tlast    // doc_end
);
  import jbl_pkg::*;

  localparam logic [RES_CNT_W-1:0] ROOM_LIMIT = RES_CNT_W'(RES_DEPTH - 2);

  // saturating increment of a position counter
  function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // fit a counter into a result field
  function automatic logic [FIELD_WIDTH-1:0] to_field(input logic [POS_WIDTH-1:0] v);
    logic [POS_WIDTH+FIELD_WIDTH-1:0] ext;
    ext = {{FIELD_WIDTH{1'b0}}, v};
    return ext[FIELD_WIDTH-1:0];
  endfunction

  function automatic res_t mk_res(input logic [3:0] kind,
                                  input logic [POS_WIDTH-1:0] st,
                                  input logic [POS_WIDTH-1:0] len);
    res_t r;
    r.kind    = kind;
    r.start   = to_field(st);
    r.length  = to_field(len);
    r.doc_end = 1'b0;
    r.run_end = 1'b0;
    return r;
  endfunction

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // lexer state
  mode_t                mode, mode_next;
  logic [2:0]           esc, esc_next;
  lit_t                 lit, lit_next_q;
  logic [POS_WIDTH-1:0] pos, pos_next;
  logic [POS_WIDTH-1:0] spos, spos_next;
  logic [POS_WIDTH-1:0] rlen, rlen_next;

  // result queue
  res_t                 fifo [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [RES_CNT_W-1:0] count, count_next;

  // lexer outputs for the held byte
  res_t       res [2];
  logic [1:0] res_n;
  logic       relex;
  logic       tail_idx;
  prim_out_t  po_cont, po_new;

  logic room, advance, pop;
  logic [RES_CNT_W-1:0] push_cnt;

  assign room          = (count <= ROOM_LIMIT);
  assign advance       = in_valid && room;
  assign s_axis_tready = !in_valid || room;
  assign pop           = m_axis_tvalid && m_axis_tready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // recogniser outcomes: continuing a primitive, or starting one on this byte
  assign po_cont = prim_eval(lit, in_byte);
  assign po_new  = prim_eval(L_INIT, in_byte);

  // lexer step for the held byte
  always_comb begin
    mode_next  = mode;
    esc_next   = esc;
    lit_next_q = lit;
    pos_next   = pos;
    spos_next  = spos;
    rlen_next  = rlen;
    res[0]     = mk_res(K_NONE, '0, '0);
    res[1]     = mk_res(K_NONE, '0, '0);
    res_n      = 2'd0;
    relex      = 1'b0;
    tail_idx   = 1'b0;

    case (mode)
      // inside a string
      M_STR: begin
        if (esc == ESC_NONE) begin
          if (in_byte == CH_QUOTE) begin
            res[res_n[0]] = mk_res(K_STRING, spos, rlen);
            res_n         = res_n + 2'd1;
            mode_next     = M_IDLE;
          end else if (in_byte < CTRL_LIMIT) begin
            res[res_n[0]] = mk_res(K_INVALID, spos, rlen);
            res_n         = res_n + 2'd1;
            mode_next     = M_ERR;
          end else begin
            if (in_byte == CH_BSLASH) esc_next = ESC_BSLASH;
            rlen_next = sat_inc(rlen);
          end
        end else if (esc == ESC_BSLASH) begin
          if ((in_byte == CH_QUOTE) || (in_byte == "n") || (in_byte == CH_BSLASH) ||
              (in_byte == "/") || (in_byte == "t") || (in_byte == "r") ||
              (in_byte == "b") || (in_byte == "f")) begin
            esc_next  = ESC_NONE;
            rlen_next = sat_inc(rlen);
          end else if (in_byte == "u") begin
            esc_next  = ESC_HEX0;
            rlen_next = sat_inc(rlen);
          end else begin
            res[res_n[0]] = mk_res(K_INVALID, spos, rlen);
            res_n         = res_n + 2'd1;
            mode_next     = M_ERR;
          end
        end else begin
          if (is_hex(in_byte)) begin
            esc_next  = (esc + 3'd1 >= ESC_HEX_END) ? ESC_NONE : esc + 3'd1;
            rlen_next = sat_inc(rlen);
          end else begin
            res[res_n[0]] = mk_res(K_INVALID, spos, rlen);
            res_n         = res_n + 2'd1;
            mode_next     = M_ERR;
          end
        end
      end
      // inside a primitive
      M_PRIM: begin
        if (po_cont.bad) begin
          res[res_n[0]] = mk_res(K_INVALID, spos, rlen);
          res_n         = res_n + 2'd1;
          mode_next     = M_ERR;
        end else if (po_cont.emit_ok) begin
          res[res_n[0]] = mk_res(K_PRIM, spos, rlen);
          res_n         = res_n + 2'd1;
          mode_next     = M_IDLE;
          relex         = 1'b1;
        end else begin
          rlen_next = sat_inc(rlen);
          if (po_cont.done) begin
            res[res_n[0]] = mk_res(K_PRIM, spos, rlen_next);
            res_n         = res_n + 2'd1;
            mode_next     = M_IDLE;
          end else begin
            lit_next_q = po_cont.nx;
          end
        end
      end
      default: begin
      end
    endcase

    // between tokens, or the byte that ended a number
    if ((mode == M_IDLE) || relex) begin
      case (in_byte)
        " ", "\t", "\r", "\n": begin
        end
        "{": begin
          res[res_n[0]] = mk_res(K_OBJ_BEGIN, pos, POS_WIDTH'(1));
          res_n         = res_n + 2'd1;
        end
        "}": begin
          res[res_n[0]] = mk_res(K_OBJ_END, pos, POS_WIDTH'(1));
          res_n         = res_n + 2'd1;
        end
        "[": begin
          res[res_n[0]] = mk_res(K_ARR_BEGIN, pos, POS_WIDTH'(1));
          res_n         = res_n + 2'd1;
        end
        "]": begin
          res[res_n[0]] = mk_res(K_ARR_END, pos, POS_WIDTH'(1));
          res_n         = res_n + 2'd1;
        end
        ",": begin
          res[res_n[0]] = mk_res(K_COMMA, pos, POS_WIDTH'(1));
          res_n         = res_n + 2'd1;
        end
        ":": begin
          res[res_n[0]] = mk_res(K_COLON, pos, POS_WIDTH'(1));
          res_n         = res_n + 2'd1;
        end
        CH_QUOTE: begin
          mode_next = M_STR;
          spos_next = sat_inc(pos);
          rlen_next = '0;
          esc_next  = ESC_NONE;
        end
        default: begin
          // first byte of a primitive
          spos_next = pos;
          if (po_new.bad) begin
            res[res_n[0]] = mk_res(K_INVALID, pos, '0);
            res_n         = res_n + 2'd1;
            mode_next     = M_ERR;
            rlen_next     = '0;
          end else begin
            mode_next  = M_PRIM;
            rlen_next  = POS_WIDTH'(1);
            lit_next_q = po_new.nx;
          end
        end
      endcase
    end

    // end of document closes any pending token
    if (in_last) begin
      if (mode_next == M_STR) begin
        res[res_n[0]] = mk_res(K_INVALID, spos_next, rlen_next);
        res_n         = res_n + 2'd1;
      end else if (mode_next == M_PRIM) begin
        res[res_n[0]] = mk_res(lit_complete(lit_next_q) ? K_PRIM : K_INVALID,
                               spos_next, rlen_next);
        res_n         = res_n + 2'd1;
      end
      if (res_n == 2'd0) begin
        res[0] = mk_res(K_NONE, '0, '0);
        res_n  = 2'd1;
      end
      mode_next  = M_IDLE;
      esc_next   = ESC_NONE;
      lit_next_q = L_INIT;
      pos_next   = '0;
      spos_next  = '0;
      rlen_next  = '0;
    end else begin
      pos_next = sat_inc(pos);
    end

    // flags on the final item of this byte
    if (res_n != 2'd0) begin
      tail_idx              = ~res_n[0];
      res[tail_idx].run_end = 1'b1;
      res[tail_idx].doc_end = in_last;
    end
  end

  // lexer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      esc  <= ESC_NONE;
      lit  <= L_INIT;
      pos  <= '0;
      spos <= '0;
      rlen <= '0;
    end else if (advance) begin
      mode <= mode_next;
      esc  <= esc_next;
      lit  <= lit_next_q;
      pos  <= pos_next;
      spos <= spos_next;
      rlen <= rlen_next;
    end
  end

  // result queue
  assign push_cnt   = advance ? RES_CNT_W'(res_n) : '0;
  assign count_next = count + push_cnt - RES_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt[RES_PTR_W-1:0];
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (res_n != 2'd0)) fifo[wr_ptr] <= res[0];
    if (advance && (res_n == 2'd2)) fifo[wr_ptr + 1'b1] <= res[1];
  end

  // result stream
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = {fifo[rd_ptr].length, fifo[rd_ptr].start};
  assign m_axis_tuser  = {fifo[rd_ptr].run_end, fifo[rd_ptr].kind};
  assign m_axis_tlast  = fifo[rd_ptr].doc_end;

`ifndef SYNTHESIS
  // queue never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overfilled");

  // the final byte of a document always yields a result
  a_last_yields: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |-> res_n != 2'd0)
    else $error("document end produced no item");

  // the lexer returns to document start after the final byte
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> mode == M_IDLE && pos == '0 && rlen == '0)
    else $error("lexer state not cleared at document end");

  // error mode holds until the document ends
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    advance && !in_last && mode == M_ERR |=> mode == M_ERR)
    else $error("left error mode before document end");
`endif

endmodule
`default_nettype wire
